// ===== sv/vfr_pkg.sv =====
// shared constants, types and the crc-8 byte step for the vision frame receiver
package vfr_pkg;

	localparam int COUNT_W = 5;
	localparam int HELD_N = 12;
	localparam int BURST_N = 14;
	localparam int BURST_IDX_W = 4;
	localparam int ELAPSED_BITS_DEF = 32;

	localparam logic [COUNT_W-1:0] FRAME_LEN = 5'd15;
	localparam logic [COUNT_W-1:0] CRC_POS = 5'd13;
	localparam logic [COUNT_W-1:0] END_POS = 5'd14;
	localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd16;

	localparam logic [7:0] HEAD_MARK = 8'h53;
	localparam logic [7:0] END_MARK = 8'h45;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'h00;

	localparam logic [15:0] TIMEOUT_RST = 16'd500;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic done;
		logic ok;
	} check_t;

	typedef logic [HELD_N-1:0][7:0] held_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/vfr_frame_check.sv =====
// byte counter, running crc, burst store and frame acceptance check
module vfr_frame_check import vfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output check_t     chk,
	output held_t      frame_bytes
);

	logic [COUNT_W-1:0] count_q;
	logic [7:0]         crc_q;
	logic [7:0]         burst_q [BURST_N];
	logic [7:0]         crc_next;

	assign crc_next = crc8_byte(crc_q, data_byte);

	always_ff @(posedge clk) begin
		if (step && (count_q < END_POS)) begin
			burst_q[count_q[BURST_IDX_W-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (step) begin
			if (last_byte) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
			end else begin
				if (count_q < CRC_POS) begin
					crc_q <= crc_next;
				end
				if (count_q < COUNT_SAT) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		chk.done = step && last_byte;
		chk.ok   = chk.done && (count_q == END_POS) && (burst_q[0] == HEAD_MARK)
			&& (data_byte == END_MARK) && (burst_q[CRC_POS[BURST_IDX_W-1:0]] == crc_q);
		for (int i = 0; i < HELD_N; i++) begin
			frame_bytes[i] = burst_q[i+1];
		end
	end

endmodule

// ===== sv/vfr_link_timer.sv =====
// saturating elapsed-tick counter and online flag
module vfr_link_timer import vfr_pkg::*; #(
	parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        accept,
	input  logic [15:0] timeout,
	output logic        online_d
);

	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [ELAPSED_BITS-1:0] elapsed_next;
	logic                    ever_q;
	logic                    ever_next;

	always_comb begin
		elapsed_next = elapsed_q;
		if (accept) begin
			elapsed_next = '0;
		end else if (tick && (elapsed_q != '1)) begin
			elapsed_next = elapsed_q + 1'b1;
		end
		ever_next = ever_q | accept;
		online_d  = ever_next && (elapsed_next <= {{(ELAPSED_BITS-16){1'b0}}, timeout});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			ever_q    <= 1'b0;
		end else begin
			elapsed_q <= elapsed_next;
			ever_q    <= ever_next;
		end
	end

endmodule

// ===== sv/vision_frame_receiver_crc8.sv =====
// top level of the vision frame receiver with crc-8 check
// One beat in per cycle while result_ready is high; each beat is a received byte or a
// millisecond tick and gives exactly one result beat. An accepted beat lands in an input
// register and its result, checked against the running crc-8 of the burst, lands in the
// output register when the input register advances, which needs the output register empty
// or result_ready high. While the output register waits on result_ready the input register
// holds its beat and item_ready is low; at most one further beat enters behind a waiting
// result. A frame is taken when its burst has 15 bytes, header 0x53, trailer 0x45 and byte
// 13 equal to the crc-8 (poly 0x31) of bytes 0 to 12; it updates the held words (low byte
// first) and restarts the elapsed-tick counter behind the online flag.
module vision_frame_receiver_crc8 import vfr_pkg::*; #(
	parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        frame_done,
	output logic        frame_ok,
	output logic [7:0]  detect_byte,
	output logic [7:0]  shoot_request,
	output logic [15:0] yaw_word,
	output logic [15:0] pitch_word,
	output logic [15:0] x_word,
	output logic [15:0] y_word,
	output logic [15:0] depth_word,
	output logic        online
);

	logic [15:0] timeout_q;
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        adv;
	logic        out_valid_q;
	logic        done_q;
	logic        ok_q;
	logic        online_q;
	held_t       held_q;
	held_t       frame_bytes;
	check_t      chk;
	logic        online_d;

	assign adv        = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1 <= action;
			data_s1   <= data_byte;
			last_s1   <= last_byte;
		end
	end

	vfr_frame_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv && (action_s1 == ACT_BYTE)),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.chk         (chk),
		.frame_bytes (frame_bytes)
	);

	vfr_link_timer #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (adv && (action_s1 == ACT_TICK)),
		.accept   (chk.ok),
		.timeout  (timeout_q),
		.online_d (online_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (chk.ok) begin
			held_q <= frame_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_q   <= chk.done;
			ok_q     <= chk.ok;
			online_q <= online_d;
		end
	end

	assign result_valid  = out_valid_q;
	assign frame_done    = done_q;
	assign frame_ok      = ok_q;
	assign online        = online_q;
	assign detect_byte   = held_q[0];
	assign shoot_request = held_q[1];
	assign yaw_word      = {held_q[3], held_q[2]};
	assign pitch_word    = {held_q[5], held_q[4]};
	assign x_word        = {held_q[7], held_q[6]};
	assign y_word        = {held_q[9], held_q[8]};
	assign depth_word    = {held_q[11], held_q[10]};

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_ok |-> frame_done)
		else $error("frame_ok without frame_done");

	a_ok_online: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_ok |-> online)
		else $error("accepted frame not reported online");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1))
		else $error("input stage lost a beat while stalled");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		chk.ok |=> held_q == $past(frame_bytes))
		else $error("held fields not loaded on accepted frame");

endmodule
